// File: hdl/bsa_pkg.sv
// Package for the bitmap slot allocator: sizes, status codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package bsa_pkg;

  localparam int WORDS_PER_GROUP = 4;
  localparam int GROUP_COUNT     = 16;
  localparam int BITS_PER_WORD   = 64;
  localparam int TOTAL_WORDS     = WORDS_PER_GROUP * GROUP_COUNT;
  localparam int TOTAL_SLOTS     = TOTAL_WORDS * BITS_PER_WORD;

  localparam int SLOT_W  = 12;
  localparam int COUNT_W = 13;
  localparam int BIT_W   = $clog2(BITS_PER_WORD);
  localparam int WORD_AW = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int HINT_W  = $clog2(GROUP_COUNT + 1);
  localparam int J_W     = $clog2(WORDS_PER_GROUP + 1);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_OOR       = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_FIRST,
    S_ALLOC_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    rd_cur;
    logic    rd_next;
    logic    step;
    logic    wr_alloc;
    logic    wr_free;
    logic    pend_load;
    status_e pend_status;
    logic    pend_alloc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic hint_full;
    logic oor;
    logic word_full;
    logic last_word;
    logic bit_set;
  } sts_t;

endpackage

// File: hdl/bsa_ctrl.sv
// Controller FSM of the bitmap slot allocator: sequences the word scan of an
// allocate and the read-modify-write of a free. Uses bsa_pkg.
module bsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bsa_pkg::sts_t sts_i,
  output bsa_pkg::cmd_t cmd_o
);
  import bsa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.pend_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (req_type_i == REQ_FREE) ? S_FREE_RD : S_ALLOC_FIRST;
        end
      end
      S_ALLOC_FIRST: begin
        if (sts_i.hint_full) begin
          cmd_o.pend_load   = 1'b1;
          cmd_o.pend_status = ST_FULL;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_ALLOC_SCAN;
        end
      end
      S_ALLOC_SCAN: begin
        if (!sts_i.word_full) begin
          cmd_o.wr_alloc    = 1'b1;
          cmd_o.pend_load   = 1'b1;
          cmd_o.pend_status = ST_OK;
          cmd_o.pend_alloc  = 1'b1;
          state_d = S_RESP;
        end else begin
          // The next word is read while this one is checked.
          cmd_o.step = 1'b1;
          if (sts_i.last_word) begin
            cmd_o.pend_load   = 1'b1;
            cmd_o.pend_status = ST_FULL;
            state_d = S_RESP;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_FREE_RD: begin
        if (sts_i.oor) begin
          cmd_o.pend_load   = 1'b1;
          cmd_o.pend_status = ST_OOR;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd_o.pend_load = 1'b1;
        if (sts_i.bit_set) begin
          cmd_o.wr_free     = 1'b1;
          cmd_o.pend_status = ST_OK;
        end else begin
          cmd_o.pend_status = ST_NOT_ALLOC;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/bsa_dpath.sv
// Datapath of the bitmap slot allocator: occupancy memory with per-word valid
// bits, scan pointers, search hint, live count and result registers. Uses bsa_pkg.
module bsa_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_type_i,
  input  logic [bsa_pkg::SLOT_W-1:0]   slot_index_i,
  input  bsa_pkg::cmd_t                cmd_i,
  output bsa_pkg::sts_t                sts_o,
  output logic [1:0]                   status_o,
  output logic [bsa_pkg::SLOT_W-1:0]   slot_out_o,
  output logic [bsa_pkg::COUNT_W-1:0]  live_count_o
);
  import bsa_pkg::*;

  logic [BITS_PER_WORD-1:0] mem [TOTAL_WORDS];
  logic [TOTAL_WORDS-1:0]   vld_q;

  logic [BITS_PER_WORD-1:0] rdata_q;
  logic                     rvld_q;
  logic [BITS_PER_WORD-1:0] rword;

  logic [SLOT_W-1:0]  idx_q;
  logic [WORD_AW-1:0] w_q;
  logic [J_W-1:0]     j_q;
  logic [HINT_W-1:0]  g_q;
  logic [HINT_W-1:0]  hint_q;
  logic [COUNT_W-1:0] count_q;

  status_e            pend_status_q;
  logic [SLOT_W-1:0]  pend_slot_q;
  logic [1:0]         out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [COUNT_W-1:0] out_live_q;

  logic [WORD_AW-1:0] raddr;
  logic [WORD_AW-1:0] idx_word;
  logic [HINT_W-1:0]  idx_group;
  logic [BIT_W-1:0]   free_bit;
  logic [BIT_W-1:0]   zero_bit;
  logic [SLOT_W-1:0]  pend_slot_d;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [BITS_PER_WORD-1:0] w);
    logic [BIT_W-1:0] k;
    k = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!w[i]) k = BIT_W'(i);
    end
    return k;
  endfunction

  assign idx_word  = WORD_AW'(idx_q >> BIT_W);
  assign idx_group = HINT_W'(idx_word / WORDS_PER_GROUP);
  assign free_bit  = idx_q[BIT_W-1:0];
  assign rword     = rvld_q ? rdata_q : '0;
  assign zero_bit  = lowest_zero(rword);
  assign raddr     = cmd_i.rd_next ? w_q + WORD_AW'(1) : w_q;

  assign sts_o.hint_full = (hint_q >= HINT_W'(GROUP_COUNT));
  assign sts_o.oor       = (COUNT_W'(idx_q) >= COUNT_W'(TOTAL_SLOTS));
  assign sts_o.word_full = &rword;
  assign sts_o.last_word = (w_q == WORD_AW'(TOTAL_WORDS - 1));
  assign sts_o.bit_set   = rword[free_bit];

  // Memory read and write ports; a word never written reads as all free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cur || cmd_i.rd_next) begin
      rdata_q <= mem[raddr];
      rvld_q  <= vld_q[raddr];
    end
    if (cmd_i.wr_alloc) begin
      mem[w_q] <= rword | (BITS_PER_WORD'(1) << zero_bit);
    end else if (cmd_i.wr_free) begin
      mem[w_q] <= rword & ~(BITS_PER_WORD'(1) << free_bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      hint_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.wr_alloc || cmd_i.wr_free) vld_q[w_q] <= 1'b1;
      if (cmd_i.wr_alloc) begin
        count_q <= count_q + COUNT_W'(1);
      end else if (cmd_i.wr_free) begin
        if (count_q != '0) count_q <= count_q - COUNT_W'(1);
        if (hint_q > idx_group) hint_q <= idx_group;
      end else if (cmd_i.step && (j_q == J_W'(WORDS_PER_GROUP - 1))) begin
        // Whole group found full: the hint moves past it.
        hint_q <= g_q + HINT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= slot_index_i;
      j_q   <= '0;
      g_q   <= hint_q;
      if (req_type_i == REQ_FREE) begin
        w_q <= WORD_AW'(slot_index_i >> BIT_W);
      end else begin
        w_q <= WORD_AW'(hint_q * WORDS_PER_GROUP);
      end
    end else if (cmd_i.step) begin
      w_q <= w_q + WORD_AW'(1);
      if (j_q == J_W'(WORDS_PER_GROUP - 1)) begin
        j_q <= '0;
        g_q <= g_q + HINT_W'(1);
      end else begin
        j_q <= j_q + J_W'(1);
      end
    end
  end

  always_comb begin
    if (cmd_i.pend_alloc) begin
      pend_slot_d = SLOT_W'({w_q, zero_bit});
    end else if (cmd_i.pend_status == ST_FULL) begin
      pend_slot_d = '0;
    end else begin
      pend_slot_d = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_status_q <= cmd_i.pend_status;
      pend_slot_q   <= pend_slot_d;
    end
    if (cmd_i.out_load) begin
      out_status_q <= pend_status_q;
      out_slot_q   <= pend_slot_q;
      out_live_q   <= count_q;
    end
  end

  assign status_o     = out_status_q;
  assign slot_out_o   = out_slot_q;
  assign live_count_o = out_live_q;

endmodule

// File: hdl/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: joins the controller FSM and the
// datapath. Uses bsa_pkg, bsa_ctrl and bsa_dpath.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------
//   in      | in_valid_i/in_ready_o | req_type_i, slot_index_i
//   out     | out_valid_o/out_ready_i | status_o, slot_out_o, live_count_o
//
// An allocate examines one occupancy word per cycle from the hint group on,
// reading 0..64 words up to the last word (none when the hint is already past
// the last group). An out-of-range free touches no memory.
// Any other free reads its word and writes it back only if the slot was allocated.
// One request is in flight at a time; the next is accepted once the result has
// moved to the output register, even while that result waits for out_ready_i.
// Reset clears the occupancy valid bits, the hint and the live count at once.
module bitmap_slot_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [bsa_pkg::SLOT_W-1:0]  slot_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [bsa_pkg::SLOT_W-1:0]  slot_out_o,
  output logic [bsa_pkg::COUNT_W-1:0] live_count_o
);
  import bsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsa_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .slot_index_i (slot_index_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status_o),
    .slot_out_o   (slot_out_o),
    .live_count_o (live_count_o)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while one is in flight");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> live_count_o <= COUNT_W'(TOTAL_SLOTS))
    else $error("live count above capacity");

  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> slot_out_o == '0)
    else $error("pool-full result carries a nonzero slot");
`endif

endmodule
